FILE: hdl/cat_pkg.sv
// Package for the camera auto-shoot trigger: widths, register indexes, mode codes.
// Used by every module of the block; depends on nothing.
package cat_pkg;
	localparam int POS_BITS = 24;
	localparam int COUNT_BITS = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int FULL_TURN = 36000;
	localparam logic [23:0] RING_MAX = 24'hFFFFFF;

	typedef enum logic [2:0] {
		REG_MODE = 3'd0, REG_PERIOD = 3'd1, REG_SPACING = 3'd2, REG_CINT = 3'd3,
		REG_CSTART = 3'd4, REG_ORIG_X = 3'd5, REG_ORIG_Y = 3'd6, REG_DELAY = 3'd7
	} reg_idx_t;

	localparam logic [2:0] MODE_PERIODIC = 3'd1;
	localparam logic [2:0] MODE_DISTANCE = 3'd2;
	localparam logic [2:0] MODE_CIRCLE = 3'd3;
	localparam logic [2:0] MODE_SURVEY = 3'd4;

	typedef struct packed {
		logic [31:0] now_ms;
		logic signed [POS_BITS-1:0] pos_east;
		logic signed [POS_BITS-1:0] pos_north;
		logic signed [15:0] heading;
	} tick_t;

	typedef struct packed {
		logic shoot;
		logic [15:0] trigger_count;
		logic [23:0] next_ring;
	} result_t;

	typedef struct packed {
		logic clr;
		logic sq_go;
	} alu_ctl_t;
endpackage

FILE: hdl/cat_if.sv
// Valid/ready channel carrying one payload of a given type.
// Depends on nothing.
interface cat_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/camera_autoshoot_trigger.sv
// Channel  | Dir | Payload
// tick     | in  | now_ms, pos_east, pos_north, heading
// result   | out | shoot, trigger_count, next_ring
// cfg      | in  | cfg_we, cfg_idx, cfg_data (write only)
// A tick goes S_IDLE, S_DEC, S_OUT in stop and periodic modes; it passes S_SQ1, S_SQ2
// and S_SQW before S_DEC in distance and survey modes (two products through the shared
// squarer, then the accumulate) and S_DIV and S_DIVW in circle mode (16-step shared divider).
// Any config write clears the counters and reruns the divider for the block count;
// ready stays low during the write and until the divider has returned the block count.
// Reset is asynchronous; the result stays registered until taken, and ready drops
// while a tick is in work or a result waits.
module camera_autoshoot_trigger import cat_pkg::*; (
	input logic clk,
	input logic arst_n,
	cat_if.sink tick,
	cat_if.source result,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_idx,
	input logic [CFG_DATA_BITS-1:0] cfg_data
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001, S_SQ1 = 8'b00000010, S_SQ2 = 8'b00000100,
		S_SQW = 8'b00001000, S_DIV = 8'b00010000, S_DIVW = 8'b00100000,
		S_DEC = 8'b01000000, S_OUT = 8'b10000000
	} state_t;

	state_t state_q;
	logic [2:0] mode_q;
	logic [31:0] period_q, plast_q, slast_q;
	logic [15:0] spacing_q, cint_q, cstart_q, delay_q;
	logic signed [POS_BITS-1:0] ox_q, oy_q, le_q, ln_q;
	logic [8:0] lblk_q, btot_q;
	logic [23:0] ring_q;
	logic [COUNT_BITS-1:0] cnt_q;
	tick_t t_q;
	result_t res_q;
	logic bt_pend_q, bt_phase_q;
	logic [15:0] ci_eff;

	alu_ctl_t ctl;
	logic [32:0] sq_op;
	logic [63:0] acc;
	logic div_start, div_done;
	logic [15:0] div_a, div_b, quo;

	assign ci_eff = (cint_q < 16'd100) ? 16'd100 : (cint_q > 16'd35999 ? 16'd35999 : cint_q);

	// Heading offset reduced to 0..35999
	logic signed [17:0] st_mod, cdiff;
	logic [15:0] cpos;
	assign st_mod = (cstart_q >= 16'(FULL_TURN)) ? 18'(cstart_q) - 18'(FULL_TURN) : 18'(cstart_q);
	assign cdiff = 18'(t_q.heading) - st_mod;
	always_comb begin
		if (cdiff < -18'(FULL_TURN)) cpos = 16'(cdiff + 18'(2 * FULL_TURN));
		else if (cdiff < 0) cpos = 16'(cdiff + 18'(FULL_TURN));
		else if (cdiff >= 18'(FULL_TURN)) cpos = 16'(cdiff - 18'(FULL_TURN));
		else cpos = 16'(cdiff);
	end

	logic is_dist;
	assign is_dist = (mode_q == MODE_DISTANCE);
	always_comb begin
		if (state_q == S_SQ1)
			sq_op = is_dist ? 33'(t_q.pos_east) - 33'(le_q) : 33'(ox_q) - 33'(t_q.pos_east);
		else
			sq_op = is_dist ? 33'(t_q.pos_north) - 33'(ln_q) : 33'(oy_q) - 33'(t_q.pos_north);
	end

	assign ctl.clr = (state_q == S_IDLE);
	assign ctl.sq_go = (state_q == S_SQ1) || (state_q == S_SQ2);

	cat_sq_unit u_sq (.clk(clk), .ctl(ctl), .operand(sq_op), .acc(acc));

	assign div_start = ((state_q == S_IDLE) && bt_pend_q && !bt_phase_q)
		|| (state_q == S_DIV);
	assign div_a = (state_q == S_DIV) ? cpos : 16'(FULL_TURN);
	assign div_b = ci_eff;
	cat_divider u_div (.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done), .quotient(quo));

	assign tick.ready = (state_q == S_IDLE) && !bt_pend_q && !cfg_we;
	assign result.valid = (state_q == S_OUT);
	assign result.payload = res_q;

	// Decision, used in S_DEC
	logic [8:0] blk, ba, bb, dd, ee;
	logic [31:0] el_p, el_s;
	logic [24:0] nr;
	logic [23:0] ring_nx;
	logic [31:0] sp_sq;
	logic [47:0] ring_sq;
	logic fire_p, hit_d, hit_c, hit_s, fire_s;
	logic [COUNT_BITS-1:0] cnt_nx;
	assign blk = quo[8:0];
	assign ba = (blk > lblk_q) ? blk : lblk_q;
	assign bb = (blk > lblk_q) ? lblk_q : blk;
	assign dd = ba - bb;
	assign ee = bb + btot_q - ba;
	assign el_p = t_q.now_ms - plast_q;
	assign el_s = t_q.now_ms - slast_q;
	assign nr = 25'(ring_q) + 25'(spacing_q);
	assign ring_nx = nr[24] ? RING_MAX : nr[23:0];
	assign sp_sq = spacing_q * spacing_q;
	assign ring_sq = ring_q * ring_q;
	assign fire_p = (mode_q == MODE_PERIODIC) && (el_p > period_q);
	assign hit_d = (mode_q == MODE_DISTANCE) && (acc > 64'(sp_sq));
	assign hit_c = (mode_q == MODE_CIRCLE) && ((dd < ee ? dd : ee) == 9'd1);
	assign hit_s = (mode_q == MODE_SURVEY) && (acc >= 64'(ring_sq));
	assign fire_s = hit_s && (el_s >= 32'(delay_q));
	assign cnt_nx = (hit_d || hit_c || hit_s) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= '0; period_q <= 32'd1000; spacing_q <= 16'd5000;
			cint_q <= 16'd100; cstart_q <= '0; ox_q <= '0; oy_q <= '0;
			delay_q <= 16'd3000; plast_q <= '0; slast_q <= '0;
			le_q <= '0; ln_q <= '0; lblk_q <= '0; btot_q <= 9'd360;
			ring_q <= '0; cnt_q <= '0; bt_pend_q <= 1'b0; bt_phase_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_MODE: mode_q <= cfg_data[2:0];
					REG_PERIOD: period_q <= cfg_data;
					REG_SPACING: spacing_q <= cfg_data[15:0];
					REG_CINT: cint_q <= cfg_data[15:0];
					REG_CSTART: cstart_q <= cfg_data[15:0];
					REG_ORIG_X: ox_q <= cfg_data[POS_BITS-1:0];
					REG_ORIG_Y: oy_q <= cfg_data[POS_BITS-1:0];
					REG_DELAY: delay_q <= cfg_data[15:0];
				endcase
				cnt_q <= '0; le_q <= '0; ln_q <= '0; lblk_q <= '0; ring_q <= '0;
				bt_pend_q <= 1'b1;
				bt_phase_q <= 1'b0;
			end else if (state_q == S_DEC) begin
				cnt_q <= cnt_nx;
				if (fire_p) plast_q <= t_q.now_ms;
				if (hit_d) begin
					le_q <= t_q.pos_east;
					ln_q <= t_q.pos_north;
				end
				if (hit_c) lblk_q <= blk;
				if (hit_s) ring_q <= ring_nx;
				if (fire_s) slast_q <= t_q.now_ms;
			end else if (bt_pend_q && state_q == S_IDLE) begin
				// recompute block count through the divider
				if (!bt_phase_q) bt_phase_q <= 1'b1;
				else if (div_done) begin
					btot_q <= quo[8:0];
					bt_pend_q <= 1'b0;
					bt_phase_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: if (tick.valid && tick.ready) begin
					if (mode_q == MODE_DISTANCE || mode_q == MODE_SURVEY) state_q <= S_SQ1;
					else if (mode_q == MODE_CIRCLE) state_q <= S_DIV;
					else state_q <= S_DEC;
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SQW;
				S_SQW: state_q <= S_DEC;
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (div_done) state_q <= S_DEC;
				S_DEC: begin
					state_q <= S_OUT;
					res_q.shoot <= fire_p || hit_d || hit_c || fire_s;
					res_q.trigger_count <= 16'(cnt_nx);
					res_q.next_ring <= hit_s ? ring_nx : ring_q;
				end
				S_OUT: if (result.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) t_q <= tick.payload;
	end
endmodule

FILE: hdl/cat_divider.sv
// Restoring divider, one quotient bit per cycle; 16-bit dividend and divisor.
// Depends on cat_pkg.
module cat_divider import cat_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] dividend,
	input logic [15:0] divisor,
	output logic done,
	output logic [15:0] quotient
);
	logic [15:0] rem_q, quo_q, den_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [16:0] trial;

	assign trial = {rem_q, quo_q[15]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

FILE: hdl/cat_sq_unit.sv
// Shared squarer with saturating 64-bit accumulator: adds a*a for one operand per use.
// Depends on cat_pkg.
module cat_sq_unit import cat_pkg::*; (
	input logic clk,
	input alu_ctl_t ctl,
	input logic [32:0] operand,
	output logic [63:0] acc
);
	logic [31:0] mag;
	logic [63:0] prod_q;
	logic [64:0] sum;
	logic add_q;

	// operand is a 33-bit two's-complement difference
	assign mag = operand[32] ? 32'(-operand) : operand[31:0];
	assign sum = {1'b0, acc} + {1'b0, prod_q};

	always_ff @(posedge clk) begin
		prod_q <= 64'(mag) * 64'(mag);
		add_q <= ctl.sq_go;
		if (ctl.clr) acc <= '0;
		else if (add_q) acc <= sum[64] ? '1 : sum[63:0];
	end
endmodule
